/* src/ugmt_pkg.sv */
// ----------------------------------------------------------------------------
// ugmt_pkg
// Shared types, constants and the box-drawing default table for the
// codepoint-to-glyph map.
// ----------------------------------------------------------------------------
package ugmt_pkg;

  localparam int unsigned TableDepthDefault = 8192;
  localparam int unsigned IdentCount        = 256;
  localparam int unsigned RomCount          = 52;
  localparam int unsigned DefaultCount      = IdentCount + RomCount;
  localparam int unsigned LimitWidth        = 17;
  localparam logic [LimitWidth-1:0] LimitReset = 17'd256;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_LOAD    = 3'd1,
    OP_LOOKUP  = 3'd2,
    OP_ADD_DEF = 3'd3,
    OP_DEF_ONLY = 3'd4,
    OP_READ    = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DSCAN,
    S_DFILL,
    S_RDWAIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [15:0] cp;
    logic [15:0] gl;
  } pair_t;

  function automatic pair_t rom_pair(input logic [5:0] idx);
    pair_t p;
    p = '0;
    case (idx)
      6'd0:  p = '{16'h2500, 16'h00C4};
      6'd1:  p = '{16'h2501, 16'h00C4};
      6'd2:  p = '{16'h2502, 16'h00B3};
      6'd3:  p = '{16'h2503, 16'h00B3};
      6'd4:  p = '{16'h250C, 16'h00DA};
      6'd5:  p = '{16'h250D, 16'h00DA};
      6'd6:  p = '{16'h2510, 16'h00BF};
      6'd7:  p = '{16'h2511, 16'h00BF};
      6'd8:  p = '{16'h2514, 16'h00C0};
      6'd9:  p = '{16'h2515, 16'h00C0};
      6'd10: p = '{16'h2518, 16'h00D9};
      6'd11: p = '{16'h2519, 16'h00D9};
      6'd12: p = '{16'h251C, 16'h00C3};
      6'd13: p = '{16'h251D, 16'h00C3};
      6'd14: p = '{16'h2524, 16'h00B4};
      6'd15: p = '{16'h2525, 16'h00B4};
      6'd16: p = '{16'h252C, 16'h00C2};
      6'd17: p = '{16'h252D, 16'h00C2};
      6'd18: p = '{16'h2534, 16'h00C1};
      6'd19: p = '{16'h2535, 16'h00C1};
      6'd20: p = '{16'h253C, 16'h00C5};
      6'd21: p = '{16'h253D, 16'h00C5};
      6'd22: p = '{16'h2550, 16'h00CD};
      6'd23: p = '{16'h2551, 16'h00BA};
      6'd24: p = '{16'h2552, 16'h00D6};
      6'd25: p = '{16'h2553, 16'h00D5};
      6'd26: p = '{16'h2554, 16'h00D7};
      6'd27: p = '{16'h2555, 16'h00D8};
      6'd28: p = '{16'h2556, 16'h00DD};
      6'd29: p = '{16'h2557, 16'h00DE};
      6'd30: p = '{16'h2558, 16'h00CE};
      6'd31: p = '{16'h2559, 16'h00CF};
      6'd32: p = '{16'h255A, 16'h00D0};
      6'd33: p = '{16'h255B, 16'h00D1};
      6'd34: p = '{16'h255C, 16'h00D2};
      6'd35: p = '{16'h255D, 16'h00D3};
      6'd36: p = '{16'h255E, 16'h00D4};
      6'd37: p = '{16'h2580, 16'h00DF};
      6'd38: p = '{16'h2584, 16'h00DC};
      6'd39: p = '{16'h2588, 16'h00DB};
      6'd40: p = '{16'h258C, 16'h00DD};
      6'd41: p = '{16'h2590, 16'h00DE};
      6'd42: p = '{16'h2591, 16'h00B0};
      6'd43: p = '{16'h2592, 16'h00B1};
      6'd44: p = '{16'h2593, 16'h00B2};
      6'd45: p = '{16'h25A0, 16'h00FE};
      6'd46: p = '{16'h25AC, 16'h00FE};
      6'd47: p = '{16'h00A0, 16'h0020};
      6'd48: p = '{16'h00B7, 16'h00FA};
      6'd49: p = '{16'h2022, 16'h00F9};
      6'd50: p = '{16'h221A, 16'h00FB};
      6'd51: p = '{16'h2261, 16'h00F0};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

/* src/ugmt_ram.sv */
// ----------------------------------------------------------------------------
// ugmt_ram
// Simple dual-port pair store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ugmt_ram
  import ugmt_pkg::*;
#(
  parameter int unsigned Depth = TableDepthDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  pair_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output pair_t            rdata_o
);

  pair_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/unicode_glyph_map_table.sv */
// ----------------------------------------------------------------------------
// unicode_glyph_map_table
// Codepoint-to-glyph map held in an ordered pair store.
// ----------------------------------------------------------------------------
// Clear and load go straight to the emit state; read first waits for the
// registered RAM word. Lookup streams the stored pairs out of the RAM one per
// cycle and stops at the first match. Add-defaults makes one pass over the
// existing pairs to mark which of the 308 default codepoints are present,
// then steps through the default candidates to append the missing ones.
// A new word is taken only when the block is idle; a finished word waits in
// the output register while the next one is accepted.
module unicode_glyph_map_table
  import ugmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned CntW  = $clog2(TABLE_DEPTH + 1),
  parameter int unsigned AddrW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LimitWidth-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            opcode_i,
  input  logic [20:0]           codepoint_i,
  input  logic [15:0]           pair_unicode_i,
  input  logic [15:0]           pair_glyph_i,
  input  logic                  first_i,
  input  logic                  last_i,
  input  logic [AddrW-1:0]      read_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [15:0]           glyph_o,
  output logic [CntW-1:0]       count_now_o,
  output logic [15:0]           read_unicode_o,
  output logic [15:0]           read_glyph_o
);

  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);
  localparam logic [CntW:0]   DefC   = (CntW+1)'(DefaultCount);
  localparam logic [8:0]      CurLast = 9'(DefaultCount - 1);

  state_e state_q, state_d;
  logic [LimitWidth-1:0] limit_q;
  logic [CntW-1:0] cnt_q, cnt_d, pos_q, pos_d;
  logic rv_q, rv_d;
  logic [15:0] key_q, key_d;
  logic [8:0] cur_q, cur_d;
  logic [DefaultCount-1:0] pres_q, pres_d;
  logic [1:0]  rs_q, rs_d;
  logic [15:0] rg_q, rg_d, ru_q, ru_d, rrg_q, rrg_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  pair_t            wdata, rdata;
  logic             issue, accept, emit;
  logic [CntW-1:0]  base;
  pair_t            cand;

  ugmt_ram #(.Depth(TABLE_DEPTH), .AddrW(AddrW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign emit        = (state_q == S_EMIT) && (!out_valid_o || out_ready_i);
  assign issue       = (pos_q < cnt_q);
  assign base        = first_i ? '0 : cnt_q;
  assign cand        = (cur_q < 9'(IdentCount))
                       ? pair_t'{{8'h00, cur_q[7:0]}, {8'h00, cur_q[7:0]}}
                       : rom_pair(6'(cur_q - 9'(IdentCount)));

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[AddrW-1:0];
    wdata = cand;
    raddr = pos_q[AddrW-1:0];
    unique case (state_q)
      S_IDLE: begin
        raddr = read_index_i;
        if (accept && opcode_i == OP_LOAD && {1'b0, pair_glyph_i} < limit_q &&
            base != DepthC) begin
          we    = 1'b1;
          waddr = base[AddrW-1:0];
          wdata = '{pair_unicode_i, pair_glyph_i};
        end
      end
      S_DFILL: we = !pres_q[cur_q];
      default: ;
    endcase
  end

  // next state and datapath
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    rv_d  = 1'b0;
    key_d = key_q;
    cur_d = cur_q;
    pres_d = pres_q;
    rs_d = rs_q;
    rg_d = rg_q;
    ru_d = ru_q;
    rrg_d = rrg_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rs_d = ST_OK;
          rg_d = '0;
          ru_d = '0;
          rrg_d = '0;
          pos_d = '0;
          cur_d = '0;
          pres_d = '0;
          key_d = codepoint_i[15:0];
          state_d = S_EMIT;
          case (opcode_i)
            OP_CLEAR: cnt_d = '0;
            OP_LOAD: begin
              cnt_d = base;
              if ({1'b0, pair_glyph_i} < limit_q) begin
                if (base != DepthC) cnt_d = base + 1'b1;
                else rs_d = ST_FAIL;
              end
            end
            OP_LOOKUP: begin
              rs_d = ST_MISS;
              if (codepoint_i[20:16] == '0) begin
                if (cnt_q == '0) begin
                  if (codepoint_i < {4'd0, limit_q}) begin
                    rs_d = ST_OK;
                    rg_d = codepoint_i[15:0];
                  end
                end else begin
                  state_d = S_LOOK;
                end
              end
            end
            OP_ADD_DEF: begin
              if ({1'b0, cnt_q} + DefC > {1'b0, DepthC}) rs_d = ST_FAIL;
              else state_d = S_DSCAN;
            end
            OP_DEF_ONLY: begin
              cnt_d = '0;
              state_d = S_DSCAN;
            end
            OP_READ: begin
              if ({1'b0, read_index_i} < cnt_q) state_d = S_RDWAIT;
              else rs_d = ST_FAIL;
            end
            default: rs_d = ST_FAIL;
          endcase
        end
      end
      S_LOOK: begin
        if (issue) begin
          pos_d = pos_q + 1'b1;
          rv_d  = 1'b1;
        end
        if (rv_q && rdata.cp == key_q) begin
          rs_d = ST_OK;
          rg_d = rdata.gl;
          rv_d = 1'b0;
          state_d = S_EMIT;
        end else if (!rv_q && !issue) begin
          state_d = S_EMIT;
        end
      end
      S_DSCAN: begin
        if (issue) begin
          pos_d = pos_q + 1'b1;
          rv_d  = 1'b1;
        end
        if (rv_q) begin
          if (rdata.cp[15:8] == 8'h00) pres_d[rdata.cp[7:0]] = 1'b1;
          for (int k = 0; k < RomCount; k++) begin
            if (rdata.cp == rom_pair(6'(k)).cp) pres_d[IdentCount + k] = 1'b1;
          end
        end else if (!issue) begin
          state_d = S_DFILL;
        end
      end
      S_DFILL: begin
        if (!pres_q[cur_q]) cnt_d = cnt_q + 1'b1;
        cur_d = cur_q + 1'b1;
        if (cur_q == CurLast) state_d = S_EMIT;
      end
      S_RDWAIT: begin
        ru_d  = rdata.cp;
        rrg_d = rdata.gl;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (emit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= LimitReset;
      cnt_q <= '0;
      pos_q <= '0;
      rv_q <= 1'b0;
      cur_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      rv_q <= rv_d;
      cur_q <= cur_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
      if (emit) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pres_q <= pres_d;
    rs_q <= rs_d;
    rg_q <= rg_d;
    ru_q <= ru_d;
    rrg_q <= rrg_d;
    if (emit) begin
      status_o <= rs_q;
      glyph_o <= rg_q;
      count_now_o <= cnt_q;
      read_unicode_o <= ru_q;
      read_glyph_o <= rrg_q;
    end
  end

  // last_i only marks the end of a load sequence; nothing depends on it
  logic unused_last;
  assign unused_last = last_i;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC) else $error("entry count past depth");
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_IDLE || state_q == S_DFILL)) else $error("stray write");
  a_fill_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DFILL) |-> (cnt_q < DepthC)) else $error("fill overflow");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT)) else $error("word from nowhere");

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the codepoint-to-glyph map: a directed table of
// words covering every opcode and corner, then random mixes of all opcodes,
// checked against an in-bench model of the pair store.
// ----------------------------------------------------------------------------
module tb_top;
  import ugmt_pkg::*;

  localparam int unsigned Depth = TableDepthDefault;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned AddrW = $clog2(Depth);

  typedef struct packed {
    logic [2:0]       op;
    logic [20:0]      cp;
    logic [15:0]      pu;
    logic [15:0]      pg;
    logic             first;
    logic             last;
    logic [AddrW-1:0] ridx;
  } word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [15:0]     glyph;
    logic [CntW-1:0] count;
    logic [15:0]     ru;
    logic [15:0]     rg;
  } answer_t;

  typedef struct {
    word_t   w;
    logic    typed;
    answer_t a;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LimitWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  answer_t got;
  logic quiet = 1'b0;
  logic drain_done = 1'b0;
  int fails = 0;

  always #4 clk = ~clk;

  unicode_glyph_map_table u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(in_word.op), .codepoint_i(in_word.cp),
    .pair_unicode_i(in_word.pu), .pair_glyph_i(in_word.pg),
    .first_i(in_word.first), .last_i(in_word.last), .read_index_i(in_word.ridx),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(got.status), .glyph_o(got.glyph), .count_now_o(got.count),
    .read_unicode_o(got.ru), .read_glyph_o(got.rg)
  );

  // map shadow
  logic [15:0] map_cp [Depth];
  logic [15:0] map_gl [Depth];
  int unsigned map_count = 0;
  int unsigned limit_q = 256;
  answer_t pending_answers[$];

  function automatic logic in_prefix(logic [15:0] c, int unsigned n);
    for (int unsigned k = 0; k < n; k++) if (map_cp[k] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_pair(logic [15:0] c, logic [15:0] g);
    if (map_count < Depth) begin
      map_cp[map_count] = c;
      map_gl[map_count] = g;
      map_count++;
    end
  endfunction

  function automatic logic [1:0] fill_defaults();
    int unsigned old_n;
    pair_t p;
    if (IdentCount + RomCount + map_count > Depth) return ST_FAIL;
    old_n = map_count;
    for (int unsigned c = 0; c < IdentCount; c++)
      if (!in_prefix(c[15:0], old_n)) push_pair(c[15:0], c[15:0]);
    for (int unsigned r = 0; r < RomCount; r++) begin
      p = rom_pair(r[5:0]);
      if (!in_prefix(p.cp, old_n)) push_pair(p.cp, p.gl);
    end
    return ST_OK;
  endfunction

  function automatic answer_t map_apply(word_t w);
    answer_t a;
    a = '0;
    case (w.op)
      OP_CLEAR: map_count = 0;
      OP_LOAD: begin
        if (w.first) map_count = 0;
        if (w.pg < limit_q) begin
          if (map_count < Depth) push_pair(w.pu, w.pg);
          else a.status = ST_FAIL;
        end
      end
      OP_LOOKUP: begin
        a.status = ST_MISS;
        if (w.cp <= 21'hFFFF) begin
          if (map_count == 0) begin
            if (w.cp < limit_q) begin
              a.status = ST_OK;
              a.glyph = w.cp[15:0];
            end
          end else begin
            for (int unsigned k = 0; k < map_count; k++)
              if (map_cp[k] == w.cp[15:0]) begin
                a.status = ST_OK;
                a.glyph = map_gl[k];
                break;
              end
          end
        end
      end
      OP_ADD_DEF: a.status = fill_defaults();
      OP_DEF_ONLY: begin
        map_count = 0;
        a.status = fill_defaults();
      end
      OP_READ: begin
        if (w.ridx < map_count) begin
          a.ru = map_cp[w.ridx];
          a.rg = map_gl[w.ridx];
        end else a.status = ST_FAIL;
      end
      default: a.status = ST_FAIL;
    endcase
    a.count = map_count[CntW-1:0];
    return a;
  endfunction

  // result side: random stalls in bursts
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = pending_answers.pop_front();
        if (got.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, got.status); fails++;
        end
        if (got.glyph !== e.glyph) begin
          $error("glyph exp %0h got %0h", e.glyph, got.glyph); fails++;
        end
        if (got.count !== e.count) begin
          $error("count_now exp %0d got %0d", e.count, got.count); fails++;
        end
        if (got.ru !== e.ru) begin
          $error("read_unicode exp %0h got %0h", e.ru, got.ru); fails++;
        end
        if (got.rg !== e.rg) begin
          $error("read_glyph exp %0h got %0h", e.rg, got.rg); fails++;
        end
      end
    end
  end

  // valid stays high across back-to-back words; drop it only for an idle burst, a limit write or the final drain
  task automatic send_word(word_t w, logic typed, answer_t a);
    answer_t p;
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    p = map_apply(w);
    if (typed && p !== a) begin
      $error("table row disagrees with map: exp %h calc %h", a, p);
      fails++;
    end
    pending_answers.push_back(p);
  endtask

  task automatic write_limit(int unsigned v);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8400) @(posedge clk);
    cfg_data <= v[LimitWidth-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_q = v;
  endtask

  function automatic word_t mk(logic [2:0] op, logic [20:0] cp, logic [15:0] pu,
                               logic [15:0] pg, logic f, logic [AddrW-1:0] ri);
    word_t w;
    w = '{op: op, cp: cp, pu: pu, pg: pg, first: f, last: 1'b0, ridx: ri};
    return w;
  endfunction

  function automatic answer_t ans(logic [1:0] s, logic [15:0] g, int unsigned c,
                                  logic [15:0] ru, logic [15:0] rg);
    answer_t a;
    a = '{status: s, glyph: g, count: c[CntW-1:0], ru: ru, rg: rg};
    return a;
  endfunction

  function automatic word_t rand_word(int unsigned mode);
    word_t w;
    w = '0;
    w.cp = $urandom_range(0, 3) == 0 ? 21'($urandom) : 21'($urandom_range(0, 300));
    w.pu = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 300));
    w.pg = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300));
    w.first = $urandom_range(0, 9) == 0;
    w.last = $urandom_range(0, 1);
    w.ridx = $urandom_range(0, 3) == 0 ? AddrW'($urandom) : AddrW'($urandom_range(0, 40));
    case ($urandom_range(0, 19))
      0: w.op = OP_CLEAR;
      1: w.op = OP_ADD_DEF;
      2: w.op = OP_DEF_ONLY;
      3: w.op = 3'($urandom_range(6, 7));
      4, 5, 6, 7, 8, 9: w.op = OP_LOAD;
      10, 11, 12, 13, 14: w.op = OP_LOOKUP;
      default: w.op = OP_READ;
    endcase
    if (mode == 1 && w.op == OP_LOOKUP && map_count != 0)
      w.cp = {5'd0, map_cp[$urandom_range(0, map_count - 1)]};
    return w;
  endfunction

  row_t rows[$];

  initial begin
    answer_t none;
    none = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{mk(OP_LOOKUP, 21'd255, 0, 0, 0, 0), 1, ans(ST_OK, 255, 0, 0, 0)});
    rows.push_back('{mk(OP_LOOKUP, 21'd256, 0, 0, 0, 0), 1, ans(ST_MISS, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_LOOKUP, 21'h1FFFFF, 0, 0, 0, 0), 1, ans(ST_MISS, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0), 1, ans(ST_FAIL, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_LOAD, 0, 16'hFFFF, 16'd255, 1, 0), 1, ans(ST_OK, 0, 1, 0, 0)});
    rows.push_back('{mk(OP_LOAD, 0, 16'h0041, 16'd256, 0, 0), 1, ans(ST_OK, 0, 1, 0, 0)});
    rows.push_back('{mk(OP_LOAD, 0, 16'h0000, 16'd0, 0, 0), 1, ans(ST_OK, 0, 2, 0, 0)});
    rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 2, 16'hFFFF, 255)});
    rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 2), 1, ans(ST_FAIL, 0, 2, 0, 0)});
    rows.push_back('{mk(OP_LOOKUP, 21'hFFFF, 0, 0, 0, 0), 1, ans(ST_OK, 255, 2, 0, 0)});
    rows.push_back('{mk(OP_LOOKUP, 21'h10000, 0, 0, 0, 0), 1, ans(ST_MISS, 0, 2, 0, 0)});
    rows.push_back('{mk(OP_LOOKUP, 21'd5, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_ADD_DEF, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_LOOKUP, 21'hA0, 0, 0, 0, 0), 1, ans(ST_OK, 16'hA0, 309, 0, 0)});
    rows.push_back('{mk(OP_LOOKUP, 21'h2261, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 13'd309), 0, none});
    rows.push_back('{mk(OP_ADD_DEF, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 309, 0, 0)});
    rows.push_back('{mk(OP_DEF_ONLY, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 308, 0, 0)});
    rows.push_back('{mk(3'd6, 0, 0, 0, 0, 0), 1, ans(ST_FAIL, 0, 308, 0, 0)});
    rows.push_back('{mk(3'd7, 21'h1FFFFF, 16'hFFFF, 16'hFFFF, 1, 13'h1FFF), 1,
                     ans(ST_FAIL, 0, 308, 0, 0)});
    rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 0, 0)});
    foreach (rows[k]) send_word(rows[k].w, rows[k].typed, rows[k].a);

    // glyph limit extremes
    write_limit(0);
    send_word(mk(OP_LOAD, 0, 16'h10, 16'h0, 1, 0), 1, ans(ST_OK, 0, 0, 0, 0));
    send_word(mk(OP_LOOKUP, 21'd0, 0, 0, 0, 0), 1, ans(ST_MISS, 0, 0, 0, 0));
    write_limit(65536);
    send_word(mk(OP_LOAD, 0, 16'h1234, 16'hFFFF, 1, 0), 1, ans(ST_OK, 0, 1, 0, 0));
    send_word(mk(OP_LOOKUP, 21'h1234, 0, 0, 0, 0), 1, ans(ST_OK, 16'hFFFF, 1, 0, 0));
    send_word(mk(OP_CLEAR, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 0, 0));
    send_word(mk(OP_LOOKUP, 21'hFFFF, 0, 0, 0, 0), 1, ans(ST_OK, 16'hFFFF, 0, 0, 0));

    // random phases, each with its own limit
    for (int ph = 0; ph < 3; ph++) begin
      write_limit(ph == 0 ? 1 : ph == 1 ? 300 : $urandom_range(1, 65536));
      if (ph == 2) quiet = 1'b1;
      for (int k = 0; k < 25; k++) send_word(rand_word($urandom_range(0, 1)), 0, none);
    end

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    drain_done = 1'b1;
    if (fails == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #40000000;
    if (!drain_done) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule
